/* design/length_prefixed_frame_parser_assert.svh */
// assertion macros for the frame parser checker
// no dependencies; included by the checker file only
`ifndef LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH

// clocked assertion, masked while reset is high
`define LPFP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LPFP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/lpfp_pkg.sv */
// shared types for the length prefixed frame parser
// no dependencies
package lpfp_pkg;

  localparam int unsigned LEN_W = 16;
  localparam int unsigned BYTE_W = 8;

  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_index;
    logic              frame_done;
    logic              checksum_error;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] frame_opcode;
  } result_t;

endpackage

/* design/lpfp_in_reg.sv */
// input register stage of the frame parser
// uses lpfp_pkg for the byte width
module lpfp_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lpfp_pkg::BYTE_W-1:0] rx_byte,
  input  logic                      advance,
  output logic                      full,
  output logic [lpfp_pkg::BYTE_W-1:0] held_byte
);

  logic accept;

  assign in_stall = full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= rx_byte;
    end
  end

endmodule

/* design/lpfp_core.sv */
// deframing state machine and result logic of the frame parser
// uses lpfp_pkg for result_t and widths
module lpfp_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lpfp_pkg::LEN_W-1:0]  cfg_data,
  input  logic                        step,
  input  logic [lpfp_pkg::BYTE_W-1:0] rx_byte,
  output lpfp_pkg::result_t           result
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LENGTH = 3'd1;
  localparam logic [2:0] PH_OPCODE = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CHECK  = 3'd4;

  localparam logic [lpfp_pkg::BYTE_W-1:0] START_BYTE = 8'hCA;
  localparam logic [lpfp_pkg::LEN_W-1:0]  MAX_LENGTH_RESET = 16'd1024;

  logic [2:0]                  phase, phase_next;
  logic [lpfp_pkg::LEN_W-1:0]  max_length;
  logic [lpfp_pkg::LEN_W-1:0]  length_held, length_held_next;
  logic [lpfp_pkg::LEN_W-1:0]  byte_count, byte_count_next;
  logic [lpfp_pkg::BYTE_W-1:0] running_sum, running_sum_next;
  logic [lpfp_pkg::BYTE_W-1:0] opcode_held, opcode_held_next;
  logic [lpfp_pkg::LEN_W-1:0]  count_inc;

  assign count_inc = byte_count + 16'd1;

  always_comb begin
    phase_next       = phase;
    length_held_next = length_held;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    opcode_held_next = opcode_held;
    result           = '0;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == START_BYTE) begin
          phase_next       = PH_LENGTH;
          length_held_next = '0;
          running_sum_next = '0;
          byte_count_next  = '0;
        end
      end
      PH_LENGTH: begin
        if (byte_count == '0) begin
          length_held_next = {length_held[15:8], rx_byte};
          byte_count_next  = 16'd1;
        end else begin
          length_held_next = {rx_byte, length_held[7:0]};
          byte_count_next  = '0;
          phase_next       = PH_OPCODE;
        end
      end
      PH_OPCODE: begin
        opcode_held_next = rx_byte;
        phase_next       = PH_DATA;
      end
      PH_DATA: begin
        // zero or oversize length: this byte is dropped
        if (byte_count >= length_held || length_held > max_length) begin
          phase_next = PH_HUNT;
        end else begin
          running_sum_next     = running_sum + rx_byte;
          result.payload_valid = 1'b1;
          result.payload_byte  = rx_byte;
          result.payload_index = byte_count;
          byte_count_next      = count_inc;
          if (count_inc == length_held) begin
            phase_next = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        phase_next = PH_HUNT;
        if (running_sum == rx_byte) begin
          result.frame_done   = 1'b1;
          result.frame_length = length_held;
          result.frame_opcode = opcode_held;
        end else begin
          result.checksum_error = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_count <= '0;
      max_length <= MAX_LENGTH_RESET;
    end else begin
      if (cfg_write) begin
        max_length <= cfg_data;
      end
      if (step) begin
        phase      <= phase_next;
        byte_count <= byte_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_held <= '0;
      running_sum <= '0;
      opcode_held <= '0;
    end else if (step) begin
      length_held <= length_held_next;
      running_sum <= running_sum_next;
      opcode_held <= opcode_held_next;
    end
  end

endmodule

/* design/lpfp_out_reg.sv */
// result register of the frame parser
// uses lpfp_pkg for result_t
module lpfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lpfp_pkg::result_t result_in,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output lpfp_pkg::result_t result_out
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

/* design/length_prefixed_frame_parser.sv */
// top level of the length prefixed frame parser
// uses lpfp_pkg, lpfp_in_reg, lpfp_core and lpfp_out_reg
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   rx_byte
//  result    out        out_valid / out_stall payload_*, frame_*, checksum_error
//  config    in         cfg_write             cfg_data (max_length)
//
// one request per cycle sustained while out_stall is low; every byte gives exactly one result
// a request passes through the input register and then the result register on its way to a result
// the rate is set by the single state update in lpfp_core for each byte taken
// rst is synchronous: parser back to hunting, max_length back to 1024
// a stalled result holds; the input register still takes a request while the
// result register is full but about to be taken
module length_prefixed_frame_parser (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic        frame_done,
  output logic        checksum_error,
  output logic [15:0] frame_length,
  output logic [7:0]  frame_opcode
);

  logic              in_full;
  logic [7:0]        held_byte;
  logic              out_ready;
  logic              advance;
  lpfp_pkg::result_t core_result;
  lpfp_pkg::result_t out_result;

  // a held byte moves on whenever the result register has room
  assign advance = in_full && out_ready;

  lpfp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .advance   (advance),
    .full      (in_full),
    .held_byte (held_byte)
  );

  // state update and result formation for the held byte
  lpfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (advance),
    .rx_byte   (held_byte),
    .result    (core_result)
  );

  lpfp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .result_in  (core_result),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (out_result)
  );

  // unpack the result register onto the field ports
  assign payload_valid  = out_result.payload_valid;
  assign payload_byte   = out_result.payload_byte;
  assign payload_index  = out_result.payload_index;
  assign frame_done     = out_result.frame_done;
  assign checksum_error = out_result.checksum_error;
  assign frame_length   = out_result.frame_length;
  assign frame_opcode   = out_result.frame_opcode;

endmodule

/* design/lpfp_checker.sv */
// port level checks for the frame parser, bound to the top level
// uses length_prefixed_frame_parser_assert.svh
`include "length_prefixed_frame_parser_assert.svh"

module lpfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        payload_valid,
  input logic [7:0]  payload_byte,
  input logic [15:0] payload_index,
  input logic        frame_done,
  input logic        checksum_error,
  input logic [15:0] frame_length,
  input logic [7:0]  frame_opcode
);

  `LPFP_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(payload_index) && $stable(frame_length) && $stable(payload_byte), "stalled result changed")
  `LPFP_ASSERT(a_excl, clk, rst, out_valid |-> $countones({payload_valid, frame_done, checksum_error}) <= 1, "more than one kind of result")
  `LPFP_ASSERT(a_idle_payload, clk, rst, out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 16'd0, "payload fields set without payload")
  `LPFP_ASSERT(a_idle_frame, clk, rst, out_valid && !frame_done |-> frame_length == 16'd0 && frame_opcode == 8'd0, "frame fields set without frame")
  `LPFP_ASSERT_ALWAYS(a_reset, clk, $past(rst) |-> !out_valid, "result shown right after reset")

endmodule

bind length_prefixed_frame_parser lpfp_checker u_checker (.*);
